// ===== sv/stq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types, codes and constants of the sorted software timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int DEF_NUM_TIMERS = 32;
  localparam int DEF_NUM_QUEUES = 4;
  localparam logic [31:0] NO_DEADLINE = 32'hffff_ffff;

  typedef enum logic [2:0] {
    A_TICK  = 3'd0,
    A_ALLOC = 3'd1,
    A_FREE  = 3'd2,
    A_INIT  = 3'd3,
    A_SET   = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    K_GRANT  = 3'd0,
    K_FULL   = 3'd1,
    K_EXPIRY = 3'd2,
    K_DONE   = 3'd3,
    K_ERROR  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_ALLOC = 2'd1,
    ST_RUN   = 2'd2
  } slot_status_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [4:0]  timer_id;
    logic [31:0] delay_ticks;
    logic [31:0] timer_word;
    logic [1:0]  queue_select;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  slot_id;
    logic [31:0] word_out;
    logic [1:0]  queue_out;
    logic        last_of_run;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_ALLOC,
    S_CNT_RD, S_CNT_CHK, S_POP_START, S_POP_RD, S_POP_WQ, S_POP_EMIT,
    S_CMP_RD, S_CMP_WR, S_UL_RD, S_UL_CHK, S_SH_RD, S_SH_WR,
    S_INS_CHK, S_INS_CMP, S_REF_RD, S_REF, S_DONE
  } state_t;

  typedef enum logic [2:0] {IDX_HOLD, IDX_ZERO, IDX_INC, IDX_DEC, IDX_ACT} idx_op_t;
  typedef enum logic [2:0] {RD_NONE, RD_IDX, RD_IDX_M1, RD_IDX_P1, RD_IDX_PN, RD_ZERO} rd_op_t;
  typedef enum logic [1:0] {WR_NONE, WR_DATA, WR_NEW} wr_op_t;
  typedef enum logic [1:0] {ACT_HOLD, ACT_INC, ACT_DEC, ACT_SUB_N} act_op_t;
  typedef enum logic [2:0] {
    STO_NONE, STO_ID_FREE, STO_ID_RUN, STO_IDX_ALLOC, STO_LST_ALLOC
  } st_op_t;
  typedef enum logic [1:0] {SLOT_ID, SLOT_IDX, SLOT_LST, SLOT_ZERO} slot_sel_t;

  typedef struct packed {
    logic      load_in;
    logic      tick_inc;
    logic      dl_calc;
    logic      wq_wr;
    logic      wq_rd;
    logic      n_load;
    logic      nxt_refresh;
    idx_op_t   idx_op;
    rd_op_t    rd_op;
    wr_op_t    wr_op;
    act_op_t   act_op;
    st_op_t    st_op;
    logic      emit;
    kind_t     emit_kind;
    slot_sel_t slot_sel;
    logic      last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       id_bad;
    logic       q_bad;
    logic       id_running;
    logic       act_full;
    logic       due;
    logic       idx_lt_act;
    logic       idx_zero;
    logic       idx_p1_lt_act;
    logic       idxn_lt_act;
    logic       idx_last_n;
    logic       n_zero;
    logic       lst_due;
    logic       lst_ge;
    logic       lst_match;
    logic       scan_free;
    logic       idx_at_end;
    logic       out_busy;
  } sts_t;

endpackage

// ===== sv/stq_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface stq_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/sorted_software_timer_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_software_timer_queue_core
// Pool of software timers with a deadline-sorted run list and tick expiry.
// ----------------------------------------------------------------------------
// One request is handled at a time; the cost is set by walks over the
// sorted list memory: alloc scans the slots for a free one, set walks
// from the tail to the insert position, free of a running timer walks
// the whole list, and a tick that expires timers counts, pops and then
// compacts the list. A result waiting in the output register stalls
// the next one until it is taken.
module sorted_software_timer_queue_core #(
  parameter int NUM_TIMERS = stq_pkg::DEF_NUM_TIMERS,
  parameter int NUM_QUEUES = stq_pkg::DEF_NUM_QUEUES
) (
  input logic        clk,
  input logic        rst,
  stq_chan_if.sink   req,
  stq_chan_if.source rsp
);

  stq_pkg::cmd_t cmd;
  stq_pkg::sts_t sts;

  stq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  stq_dp #(
    .NUM_TIMERS (NUM_TIMERS),
    .NUM_QUEUES (NUM_QUEUES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req.data),
    .rsp_data  (rsp.data),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== sv/stq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_ctrl
// Sequencer for the timer queue: decodes each request and steps the
// datapath through scans, list walks, pops and responses.
// ----------------------------------------------------------------------------
module stq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  stq_pkg::sts_t sts,
  output stq_pkg::cmd_t cmd
);

  stq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      stq_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_in = 1'b1;
          state_next  = stq_pkg::S_DECODE;
        end
      end
      stq_pkg::S_DECODE: begin
        if (!sts.out_busy) begin
          state_next    = stq_pkg::S_IDLE;
          cmd.emit_kind = stq_pkg::K_ERROR;
          cmd.slot_sel  = stq_pkg::SLOT_ID;
          case (stq_pkg::action_t'(sts.action))
            stq_pkg::A_TICK: begin
              cmd.tick_inc = 1'b1;
              cmd.idx_op   = stq_pkg::IDX_ZERO;
              if (sts.due) begin
                state_next = stq_pkg::S_CNT_RD;
              end
            end
            stq_pkg::A_ALLOC: begin
              cmd.idx_op = stq_pkg::IDX_ZERO;
              state_next = stq_pkg::S_ALLOC;
            end
            stq_pkg::A_FREE: begin
              if (sts.id_bad) begin
                cmd.emit = 1'b1;
              end else begin
                cmd.st_op = stq_pkg::STO_ID_FREE;
                if (sts.id_running) begin
                  cmd.idx_op = stq_pkg::IDX_ZERO;
                  state_next = stq_pkg::S_UL_RD;
                end else begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = stq_pkg::K_DONE;
                end
              end
            end
            stq_pkg::A_INIT: begin
              cmd.emit = 1'b1;
              if (!(sts.id_bad || sts.q_bad)) begin
                cmd.wq_wr     = 1'b1;
                cmd.emit_kind = stq_pkg::K_DONE;
              end
            end
            stq_pkg::A_SET: begin
              if (sts.id_bad || sts.id_running || sts.act_full) begin
                cmd.emit = 1'b1;
              end else begin
                cmd.dl_calc = 1'b1;
                cmd.st_op   = stq_pkg::STO_ID_RUN;
                cmd.idx_op  = stq_pkg::IDX_ACT;
                state_next  = stq_pkg::S_INS_CHK;
              end
            end
            default: cmd.emit = 1'b1;
          endcase
        end
      end
      stq_pkg::S_ALLOC: begin
        if (sts.scan_free) begin
          cmd.st_op     = stq_pkg::STO_IDX_ALLOC;
          cmd.emit      = 1'b1;
          cmd.emit_kind = stq_pkg::K_GRANT;
          cmd.slot_sel  = stq_pkg::SLOT_IDX;
          state_next    = stq_pkg::S_IDLE;
        end else if (sts.idx_at_end) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = stq_pkg::K_FULL;
          cmd.slot_sel  = stq_pkg::SLOT_ZERO;
          state_next    = stq_pkg::S_IDLE;
        end else begin
          cmd.idx_op = stq_pkg::IDX_INC;
        end
      end
      // count the due entries at the head of the list
      stq_pkg::S_CNT_RD: begin
        if (sts.idx_lt_act) begin
          cmd.rd_op  = stq_pkg::RD_IDX;
          state_next = stq_pkg::S_CNT_CHK;
        end else begin
          cmd.n_load = 1'b1;
          state_next = stq_pkg::S_POP_START;
        end
      end
      stq_pkg::S_CNT_CHK: begin
        if (sts.lst_due) begin
          cmd.idx_op = stq_pkg::IDX_INC;
          state_next = stq_pkg::S_CNT_RD;
        end else begin
          cmd.n_load = 1'b1;
          state_next = stq_pkg::S_POP_START;
        end
      end
      stq_pkg::S_POP_START: begin
        cmd.idx_op = stq_pkg::IDX_ZERO;
        state_next = sts.n_zero ? stq_pkg::S_REF_RD : stq_pkg::S_POP_RD;
      end
      stq_pkg::S_POP_RD: begin
        cmd.rd_op  = stq_pkg::RD_IDX;
        state_next = stq_pkg::S_POP_WQ;
      end
      stq_pkg::S_POP_WQ: begin
        cmd.wq_rd  = 1'b1;
        cmd.st_op  = stq_pkg::STO_LST_ALLOC;
        state_next = stq_pkg::S_POP_EMIT;
      end
      stq_pkg::S_POP_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = stq_pkg::K_EXPIRY;
          cmd.slot_sel  = stq_pkg::SLOT_LST;
          cmd.last      = sts.idx_last_n;
          if (sts.idx_last_n) begin
            cmd.idx_op = stq_pkg::IDX_ZERO;
            state_next = stq_pkg::S_CMP_RD;
          end else begin
            cmd.idx_op = stq_pkg::IDX_INC;
            state_next = stq_pkg::S_POP_RD;
          end
        end
      end
      // move the survivors down over the popped entries
      stq_pkg::S_CMP_RD: begin
        if (sts.idxn_lt_act) begin
          cmd.rd_op  = stq_pkg::RD_IDX_PN;
          state_next = stq_pkg::S_CMP_WR;
        end else begin
          cmd.act_op = stq_pkg::ACT_SUB_N;
          state_next = stq_pkg::S_REF_RD;
        end
      end
      stq_pkg::S_CMP_WR: begin
        cmd.wr_op  = stq_pkg::WR_DATA;
        cmd.idx_op = stq_pkg::IDX_INC;
        state_next = stq_pkg::S_CMP_RD;
      end
      stq_pkg::S_UL_RD: begin
        cmd.rd_op  = stq_pkg::RD_IDX;
        state_next = stq_pkg::S_UL_CHK;
      end
      stq_pkg::S_UL_CHK: begin
        if (sts.lst_match) begin
          state_next = stq_pkg::S_SH_RD;
        end else begin
          cmd.idx_op = stq_pkg::IDX_INC;
          state_next = stq_pkg::S_UL_RD;
        end
      end
      stq_pkg::S_SH_RD: begin
        if (sts.idx_p1_lt_act) begin
          cmd.rd_op  = stq_pkg::RD_IDX_P1;
          state_next = stq_pkg::S_SH_WR;
        end else begin
          cmd.act_op = stq_pkg::ACT_DEC;
          state_next = stq_pkg::S_REF_RD;
        end
      end
      stq_pkg::S_SH_WR: begin
        cmd.wr_op  = stq_pkg::WR_DATA;
        cmd.idx_op = stq_pkg::IDX_INC;
        state_next = stq_pkg::S_SH_RD;
      end
      // walk from the tail, moving later-or-equal deadlines up one place
      stq_pkg::S_INS_CHK: begin
        if (sts.idx_zero) begin
          cmd.wr_op  = stq_pkg::WR_NEW;
          cmd.act_op = stq_pkg::ACT_INC;
          state_next = stq_pkg::S_REF_RD;
        end else begin
          cmd.rd_op  = stq_pkg::RD_IDX_M1;
          state_next = stq_pkg::S_INS_CMP;
        end
      end
      stq_pkg::S_INS_CMP: begin
        if (sts.lst_ge) begin
          cmd.wr_op  = stq_pkg::WR_DATA;
          cmd.idx_op = stq_pkg::IDX_DEC;
          state_next = stq_pkg::S_INS_CHK;
        end else begin
          cmd.wr_op  = stq_pkg::WR_NEW;
          cmd.act_op = stq_pkg::ACT_INC;
          state_next = stq_pkg::S_REF_RD;
        end
      end
      stq_pkg::S_REF_RD: begin
        cmd.rd_op  = stq_pkg::RD_ZERO;
        state_next = stq_pkg::S_REF;
      end
      stq_pkg::S_REF: begin
        cmd.nxt_refresh = 1'b1;
        state_next = (stq_pkg::action_t'(sts.action) == stq_pkg::A_TICK) ?
                     stq_pkg::S_IDLE : stq_pkg::S_DONE;
      end
      stq_pkg::S_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = stq_pkg::K_DONE;
          cmd.slot_sel  = stq_pkg::SLOT_ID;
          state_next    = stq_pkg::S_IDLE;
        end
      end
      default: state_next = stq_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== sv/stq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_dp
// Timer queue datapath: tick counter, slot status, sorted deadline list
// memory, word/queue memory, walk counters and the result register.
// ----------------------------------------------------------------------------
module stq_dp #(
  parameter int NUM_TIMERS = stq_pkg::DEF_NUM_TIMERS,
  parameter int NUM_QUEUES = stq_pkg::DEF_NUM_QUEUES
) (
  input  logic               clk,
  input  logic               rst,
  input  stq_pkg::in_item_t  req_data,
  output stq_pkg::out_item_t rsp_data,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  stq_pkg::cmd_t      cmd,
  output stq_pkg::sts_t      sts
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);

  typedef struct packed {
    logic [IW-1:0] id;
    logic [31:0]   dl;
  } lst_entry_t;

  stq_pkg::in_item_t in_r;
  logic [31:0]       tick_count;
  logic [31:0]       next_deadline;
  logic [31:0]       dl_new;
  logic [CW-1:0]     active_count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     n;
  stq_pkg::slot_status_t status [NUM_TIMERS];

  lst_entry_t    lst [NUM_TIMERS];
  lst_entry_t    lst_q;
  logic [33:0]   wq [NUM_TIMERS];
  logic [33:0]   wq_q;

  logic [IW-1:0] id_ix;
  logic [CW:0]   idx_m1, idx_p1, idx_pn, act_w;
  logic [CW:0]   rd_addr_w;
  logic [31:0]   tick_p1;
  logic [4:0]    slot_sel_v;

  assign id_ix   = IW'(in_r.timer_id);
  assign idx_m1  = {1'b0, idx} - 1'b1;
  assign idx_p1  = {1'b0, idx} + 1'b1;
  assign idx_pn  = {1'b0, idx} + {1'b0, n};
  assign act_w   = {1'b0, active_count};
  assign tick_p1 = tick_count + 32'd1;

  always_comb begin
    case (cmd.rd_op)
      stq_pkg::RD_IDX_M1: rd_addr_w = idx_m1;
      stq_pkg::RD_IDX_P1: rd_addr_w = idx_p1;
      stq_pkg::RD_IDX_PN: rd_addr_w = idx_pn;
      stq_pkg::RD_ZERO:   rd_addr_w = '0;
      default:            rd_addr_w = {1'b0, idx};
    endcase
  end

  // list memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.rd_op != stq_pkg::RD_NONE) begin
      lst_q <= lst[rd_addr_w[IW-1:0]];
    end
    case (cmd.wr_op)
      stq_pkg::WR_DATA: lst[idx[IW-1:0]] <= lst_q;
      stq_pkg::WR_NEW:  lst[idx[IW-1:0]] <= '{id: id_ix, dl: dl_new};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wq_wr) begin
      wq[id_ix] <= {in_r.timer_word, in_r.queue_select};
    end
    if (cmd.wq_rd) begin
      wq_q <= wq[lst_q.id];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= req_data;
    end
    if (cmd.dl_calc) begin
      dl_new <= tick_count + in_r.delay_ticks;
    end
    if (cmd.n_load) begin
      n <= idx;
    end
    case (cmd.idx_op)
      stq_pkg::IDX_ZERO: idx <= '0;
      stq_pkg::IDX_INC:  idx <= idx_p1[CW-1:0];
      stq_pkg::IDX_DEC:  idx <= idx_m1[CW-1:0];
      stq_pkg::IDX_ACT:  idx <= active_count;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      next_deadline <= stq_pkg::NO_DEADLINE;
      active_count  <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        status[i] <= stq_pkg::ST_FREE;
      end
    end else begin
      if (cmd.tick_inc) begin
        tick_count <= tick_p1;
      end
      if (cmd.nxt_refresh) begin
        next_deadline <= (active_count != '0) ? lst_q.dl : stq_pkg::NO_DEADLINE;
      end
      case (cmd.act_op)
        stq_pkg::ACT_INC:   active_count <= active_count + 1'b1;
        stq_pkg::ACT_DEC:   active_count <= active_count - 1'b1;
        stq_pkg::ACT_SUB_N: active_count <= active_count - n;
        default: ;
      endcase
      case (cmd.st_op)
        stq_pkg::STO_ID_FREE:   status[id_ix]          <= stq_pkg::ST_FREE;
        stq_pkg::STO_ID_RUN:    status[id_ix]          <= stq_pkg::ST_RUN;
        stq_pkg::STO_IDX_ALLOC: status[idx[IW-1:0]]    <= stq_pkg::ST_ALLOC;
        stq_pkg::STO_LST_ALLOC: status[lst_q.id]       <= stq_pkg::ST_ALLOC;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.slot_sel)
      stq_pkg::SLOT_IDX: slot_sel_v = 5'(idx);
      stq_pkg::SLOT_LST: slot_sel_v = 5'(lst_q.id);
      stq_pkg::SLOT_ZERO: slot_sel_v = '0;
      default:           slot_sel_v = in_r.timer_id;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_data.kind    <= cmd.emit_kind;
      rsp_data.slot_id <= slot_sel_v;
      if (cmd.emit_kind == stq_pkg::K_EXPIRY) begin
        rsp_data.word_out  <= wq_q[33:2];
        rsp_data.queue_out <= wq_q[1:0];
      end else begin
        rsp_data.word_out  <= '0;
        rsp_data.queue_out <= '0;
      end
      rsp_data.last_of_run <= cmd.last;
    end
  end

  always_comb begin
    sts.action        = in_r.action;
    sts.id_bad        = 32'(in_r.timer_id) >= 32'(NUM_TIMERS);
    sts.q_bad         = 32'(in_r.queue_select) >= 32'(NUM_QUEUES);
    sts.id_running    = status[id_ix] == stq_pkg::ST_RUN;
    sts.act_full      = active_count == CW'(NUM_TIMERS);
    sts.due           = tick_p1 >= next_deadline;
    sts.idx_lt_act    = idx < active_count;
    sts.idx_zero      = idx == '0;
    sts.idx_p1_lt_act = idx_p1 < act_w;
    sts.idxn_lt_act   = idx_pn < act_w;
    sts.idx_last_n    = idx_p1 == {1'b0, n};
    sts.n_zero        = n == '0;
    sts.lst_due       = lst_q.dl <= tick_count;
    sts.lst_ge        = lst_q.dl >= dl_new;
    sts.lst_match     = lst_q.id == id_ix;
    sts.scan_free     = status[idx[IW-1:0]] == stq_pkg::ST_FREE;
    sts.idx_at_end    = idx == CW'(NUM_TIMERS - 1);
    sts.out_busy      = rsp_valid;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Test of the sorted software timer queue. Requests go in on the req channel
// and a scoreboard keeps a model of the slot pool and the deadline list. It
// works out the results of each accepted request, and every result that the
// block returns is checked in order against them. Both channels idle at
// random, and the response side also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NT = stq_pkg::DEF_NUM_TIMERS;
  localparam int NQ = stq_pkg::DEF_NUM_QUEUES;

  class timer_scoreboard;
    stq_pkg::out_item_t    pending_q[$];
    int                    errors;
    logic [31:0]           ticks;
    logic [31:0]           next_dl;
    int                    active;
    logic [4:0]            order[NT];
    stq_pkg::slot_status_t status[NT];
    logic [31:0]           deadline[NT];
    logic [31:0]           word[NT];
    logic [1:0]            queue[NT];

    function void reset_state();
      ticks = 0;
      next_dl = stq_pkg::NO_DEADLINE;
      active = 0;
      errors = 0;
      foreach (status[i]) status[i] = stq_pkg::ST_FREE;
    endfunction

    function void push_result(stq_pkg::kind_t k, logic [4:0] s, logic [31:0] w,
                              logic [1:0] q, logic l);
      stq_pkg::out_item_t r;
      r.kind = k;
      r.slot_id = s;
      r.word_out = w;
      r.queue_out = q;
      r.last_of_run = l;
      pending_q.push_back(r);
    endfunction

    function void refresh_next();
      next_dl = (active > 0) ? deadline[order[0]] : stq_pkg::NO_DEADLINE;
    endfunction

    // model the effect of one accepted request
    function void note_request(stq_pkg::in_item_t it);
      int n;
      int pos;
      int s;
      logic [31:0] dl;
      case (it.action)
        stq_pkg::A_TICK: begin
          ticks = ticks + 1;
          if (ticks >= next_dl) begin
            n = 0;
            while (n < active && deadline[order[n]] <= ticks) n++;
            for (int i = 0; i < n; i++) begin
              s = order[i];
              status[s] = stq_pkg::ST_ALLOC;
              push_result(stq_pkg::K_EXPIRY, 5'(s), word[s], queue[s], i == n - 1);
            end
            for (int j = 0; j + n < active; j++) order[j] = order[j + n];
            active -= n;
            refresh_next();
          end
        end
        stq_pkg::A_ALLOC: begin
          s = -1;
          for (int i = 0; i < NT; i++) begin
            if (s < 0 && status[i] == stq_pkg::ST_FREE) s = i;
          end
          if (s < 0) begin
            push_result(stq_pkg::K_FULL, 0, 0, 0, 0);
          end else begin
            status[s] = stq_pkg::ST_ALLOC;
            push_result(stq_pkg::K_GRANT, 5'(s), 0, 0, 0);
          end
        end
        stq_pkg::A_FREE: begin
          if (status[it.timer_id] == stq_pkg::ST_RUN) begin
            pos = 0;
            while (order[pos] != it.timer_id) pos++;
            for (int j = pos; j + 1 < active; j++) order[j] = order[j + 1];
            active--;
            refresh_next();
          end
          status[it.timer_id] = stq_pkg::ST_FREE;
          push_result(stq_pkg::K_DONE, it.timer_id, 0, 0, 0);
        end
        stq_pkg::A_INIT: begin
          if (it.queue_select >= NQ) begin
            push_result(stq_pkg::K_ERROR, it.timer_id, 0, 0, 0);
          end else begin
            word[it.timer_id] = it.timer_word;
            queue[it.timer_id] = it.queue_select;
            push_result(stq_pkg::K_DONE, it.timer_id, 0, 0, 0);
          end
        end
        stq_pkg::A_SET: begin
          if (status[it.timer_id] == stq_pkg::ST_RUN || active >= NT) begin
            push_result(stq_pkg::K_ERROR, it.timer_id, 0, 0, 0);
          end else begin
            dl = ticks + it.delay_ticks;
            deadline[it.timer_id] = dl;
            status[it.timer_id] = stq_pkg::ST_RUN;
            pos = 0;
            while (pos < active && deadline[order[pos]] < dl) pos++;
            for (int j = active; j > pos; j--) order[j] = order[j - 1];
            order[pos] = it.timer_id;
            active++;
            refresh_next();
            push_result(stq_pkg::K_DONE, it.timer_id, 0, 0, 0);
          end
        end
        default: push_result(stq_pkg::K_ERROR, it.timer_id, 0, 0, 0);
      endcase
    endfunction

    function void check_result(stq_pkg::out_item_t got);
      stq_pkg::out_item_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected result kind %0d slot %0d", got.kind, got.slot_id);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.slot_id !== want.slot_id) begin
        $error("slot_id: expected %0d, got %0d", want.slot_id, got.slot_id);
        errors++;
      end
      if (got.word_out !== want.word_out) begin
        $error("word_out: expected %h, got %h", want.word_out, got.word_out);
        errors++;
      end
      if (got.queue_out !== want.queue_out) begin
        $error("queue_out: expected %0d, got %0d", want.queue_out, got.queue_out);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic no_idle;
  logic long_hold;
  bit   inited[NT];
  timer_scoreboard sb;

  stq_chan_if #(.T(stq_pkg::in_item_t))  req_if ();
  stq_chan_if #(.T(stq_pkg::out_item_t)) rsp_if ();

  sorted_software_timer_queue_core #(
    .NUM_TIMERS(NT),
    .NUM_QUEUES(NQ)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_if.valid && req_if.ready) sb.note_request(req_if.data);
      if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
    end
  end

  // response side: random stalls plus one long hold-off
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        @(negedge clk);
        rsp_if.ready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        @(negedge clk);
        rsp_if.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
    end
  end

  task automatic send(logic [2:0] act, logic [31:0] id, logic [31:0] dly,
                      logic [31:0] w, logic [31:0] q);
    stq_pkg::in_item_t it;
    int gap;
    it.action = act;
    it.timer_id = 5'(id);
    it.delay_ticks = dly;
    it.timer_word = w;
    it.queue_select = 2'(q);
    if (act == stq_pkg::A_INIT) inited[it.timer_id] = 1'b1;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.data <= it;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic send_set_random();
    int id;
    logic [31:0] dly;
    id = $urandom_range(0, NT - 1);
    for (int t = 0; t < 32 && !(inited[id] && sb.status[id] != stq_pkg::ST_RUN); t++)
      id = $urandom_range(0, NT - 1);
    if (!inited[id]) begin
      send(stq_pkg::A_INIT, id, $urandom, $urandom, $urandom_range(0, NQ - 1));
    end else begin
      dly = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 6) : $urandom;
      send(stq_pkg::A_SET, id, dly, $urandom, $urandom);
    end
  endtask

  initial begin
    int r;
    sb = new();
    sb.reset_state();
    no_idle = 1'b0;
    long_hold = 1'b0;
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    send(stq_pkg::A_INIT, 0, 0, 32'hffff_ffff, 3);
    send(stq_pkg::A_INIT, 1, 32'hffff_ffff, 0, 0);
    send(stq_pkg::A_INIT, 31, 0, 32'ha5a5_5a5a, 2);
    send(stq_pkg::A_ALLOC, 0, 0, 0, 0);
    send(stq_pkg::A_ALLOC, 0, 0, 0, 0);
    send(stq_pkg::A_SET, 0, 0, 0, 0);
    send(stq_pkg::A_SET, 0, 5, 0, 0);                // running slot: rejected
    send(stq_pkg::A_SET, 1, 0, 0, 0);                // equal deadline goes first
    send(stq_pkg::A_SET, 31, 32'hffff_ffff, 0, 0);   // never-allocated slot
    send(stq_pkg::A_TICK, 0, 0, 0, 0);
    send(stq_pkg::A_TICK, 0, 0, 0, 0);
    send(stq_pkg::A_FREE, 31, 0, 0, 0);              // unlink a running slot
    send(stq_pkg::A_FREE, 31, 0, 0, 0);              // already free
    send(stq_pkg::A_TICK, 0, 0, 0, 0);               // empty list
    send(3'd5, 31, $urandom, $urandom, 3);
    send(3'd6, 0, 0, 0, 0);
    send(3'd7, 17, 0, 0, 1);
    send(stq_pkg::A_FREE, 0, 0, 0, 0);
    send(stq_pkg::A_FREE, 1, 0, 0, 0);
    // fill the pool
    for (int i = 0; i < NT + 2; i++) send(stq_pkg::A_ALLOC, 0, 0, 0, 0);

    for (int k = 0; k < 167; k++) begin
      if (k == 60) long_hold = 1'b1;
      if (k == 100) begin
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (sb.pending_q.size() > 0) @(posedge clk);
      end
      no_idle = (k >= 120 && k < 150);
      r = $urandom_range(0, 99);
      if (r < 30)
        send(stq_pkg::A_TICK, $urandom, $urandom, $urandom, $urandom);
      else if (r < 38)
        send(stq_pkg::A_ALLOC, $urandom, $urandom, $urandom, $urandom);
      else if (r < 52)
        send(stq_pkg::A_INIT, $urandom, $urandom, $urandom, $urandom);
      else if (r < 82)
        send_set_random();
      else if (r < 96)
        send(stq_pkg::A_FREE, $urandom, $urandom, $urandom, $urandom);
      else
        send(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom);
    end
    no_idle = 1'b0;
    @(negedge clk);
    req_if.valid <= 1'b0;

    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
